>>> src/ps2md_pkg.sv
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2md_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned SCREEN_BITS    = 13;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_WHEEL_MODE    = 2'd2
  } cfg_index_t;

  localparam logic [SCREEN_BITS-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [SCREEN_BITS-1:0] RESET_HEIGHT = 13'd768;

  // Flags byte bit positions
  localparam int unsigned FLAG_LEFT   = 0;
  localparam int unsigned FLAG_RIGHT  = 1;
  localparam int unsigned FLAG_SYNC   = 3;
  localparam int unsigned FLAG_XSIGN  = 4;
  localparam int unsigned FLAG_YSIGN  = 5;

  typedef struct packed {
    logic              left;
    logic              right;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic signed [3:0] wheel;
  } pkt_t;

endpackage

`default_nettype wire

>>> src/ps2md_assembler.sv
// ----------------------------------------------------------------------------
// ps2md_assembler
// Collects mouse bytes into 3- or 4-byte packets and holds one decoded packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_assembler (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          wheel_mode,
  input  wire logic          restart,
  input  wire logic          take,
  output ps2md_pkg::pkt_t    pkt,
  output logic               pkt_valid
);
  import ps2md_pkg::*;

  logic [1:0] byte_index;
  logic [1:0] byte_index_next;
  logic [7:0] packet_bytes [3];
  logic       sync_ok;
  logic       complete;
  logic [1:0] last_index;
  pkt_t       pkt_next;
  logic [7:0] flags;
  logic [7:0] mx;
  logic [7:0] my;

  assign sync_ok    = (byte_index != 2'd0) || data_byte[FLAG_SYNC];
  assign last_index = wheel_mode ? 2'd3 : 2'd2;
  assign complete   = accept && sync_ok && (byte_index == last_index);

  always_comb begin
    byte_index_next = byte_index;
    if (accept && sync_ok) begin
      byte_index_next = complete ? 2'd0 : byte_index + 2'd1;
    end
  end

  always_comb begin
    flags = packet_bytes[0];
    mx    = packet_bytes[1];
    my    = wheel_mode ? packet_bytes[2] : data_byte;
    pkt_next.left  = flags[FLAG_LEFT];
    pkt_next.right = flags[FLAG_RIGHT];
    pkt_next.dx    = $signed({flags[FLAG_XSIGN], mx});
    pkt_next.dy    = $signed({flags[FLAG_YSIGN], my});
    pkt_next.wheel = wheel_mode ? $signed(data_byte[3:0]) : 4'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 2'd0;
    end else if (restart) begin
      byte_index <= 2'd0;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sync_ok && byte_index != 2'd3) begin
      packet_bytes[byte_index] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (complete) begin
      pkt_valid <= 1'b1;
    end else if (take) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      pkt <= pkt_next;
    end
  end

endmodule

`default_nettype wire

>>> src/ps2md_tracker.sv
// ----------------------------------------------------------------------------
// ps2md_tracker
// Moves and clamps the cursor per packet and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ps2md_pkg::pkt_t                    pkt,
  input  wire logic                               pkt_valid,
  input  wire logic [ps2md_pkg::SCREEN_BITS-1:0]  screen_width,
  input  wire logic [ps2md_pkg::SCREEN_BITS-1:0]  screen_height,
  output logic                                    take,
  output logic [COORD_BITS-1:0]                   pos_x,
  output logic [COORD_BITS-1:0]                   pos_y,
  output logic                                    left_button,
  output logic                                    right_button,
  output logic                                    click,
  output logic signed [3:0]                       wheel_delta,
  output logic                                    redraw,
  output logic                                    result_valid,
  input  wire logic                               result_stall
);
  import ps2md_pkg::*;

  localparam int unsigned EW = (COORD_BITS + 1 > SCREEN_BITS) ? COORD_BITS + 1 : SCREEN_BITS;
  localparam int unsigned SW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_held;
  logic                  shown;
  logic [COORD_BITS:0]   eff_w;
  logic [COORD_BITS:0]   eff_h;
  logic signed [SW-1:0]  sx;
  logic signed [SW-1:0]  sy;
  logic [COORD_BITS-1:0] nx;
  logic [COORD_BITS-1:0] ny;

  function automatic logic [COORD_BITS:0] eff_size(input logic [SCREEN_BITS-1:0] v);
    logic [EW-1:0] ve;
    logic [EW-1:0] lim;
    ve  = EW'(v);
    lim = EW'(1) << COORD_BITS;
    if (ve == '0) begin
      eff_size = (COORD_BITS+1)'(1);
    end else if (ve > lim) begin
      eff_size = (COORD_BITS+1)'(lim);
    end else begin
      eff_size = (COORD_BITS+1)'(ve);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_to(input logic signed [SW-1:0] v,
                                                    input logic [COORD_BITS:0] size);
    if (v < 0) begin
      clamp_to = '0;
    end else if (v >= $signed({1'b0, size})) begin
      clamp_to = COORD_BITS'(size - (COORD_BITS+1)'(1));
    end else begin
      clamp_to = COORD_BITS'(v);
    end
  endfunction

  assign take  = pkt_valid && (!result_valid || !result_stall);
  assign eff_w = eff_size(screen_width);
  assign eff_h = eff_size(screen_height);
  assign sx    = $signed({2'b00, cursor_x}) + SW'(pkt.dx);
  assign sy    = $signed({2'b00, cursor_y}) - SW'(pkt.dy);
  assign nx    = clamp_to(sx, eff_w);
  assign ny    = clamp_to(sy, eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= COORD_BITS'(RESET_WIDTH >> 1);
      cursor_y     <= COORD_BITS'(RESET_HEIGHT >> 1);
      left_held    <= 1'b0;
      shown        <= 1'b0;
      result_valid <= 1'b0;
    end else if (take) begin
      cursor_x     <= nx;
      cursor_y     <= ny;
      left_held    <= pkt.left;
      shown        <= 1'b1;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pos_x        <= nx;
      pos_y        <= ny;
      left_button  <= pkt.left;
      right_button <= pkt.right;
      click        <= pkt.left && !left_held;
      wheel_delta  <= pkt.wheel;
      redraw       <= !shown || (nx != cursor_x) || (ny != cursor_y);
    end
  end

endmodule

`default_nettype wire

>>> src/ps2_mouse_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// PS/2 mouse packet decoder with clamped cursor tracking.
// ----------------------------------------------------------------------------
// Takes one mouse byte per cycle unless stalled; a packet starts only on a
// byte with bit 3 set and is 3 bytes long, or 4 with wheel_mode on. Each
// completed packet gives one result item with the clamped cursor position,
// buttons, a click on the left button's press, the wheel delta and a redraw
// flag. A byte passes through two registers: the packet register in the
// assembler and the result register in the tracker; one byte is taken in
// every cycle unless both registers are full and the result is stalled.
// Screen size and wheel mode are to be written through the configuration
// port only while no item is in flight; the user must keep to this, as the
// block does not enforce it. A wheel_mode write restarts packet assembly.
`default_nettype none

module ps2_mouse_packet_decoder_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  byte_valid,
  output logic                                       byte_stall,
  input  wire logic [7:0]                            data_byte,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic [COORD_BITS-1:0]                      pos_x,
  output logic [COORD_BITS-1:0]                      pos_y,
  output logic                                       left_button,
  output logic                                       right_button,
  output logic                                       click,
  output logic signed [3:0]                          wheel_delta,
  output logic                                       redraw,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [ps2md_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [ps2md_pkg::SCREEN_BITS-1:0]     cfg_data
);
  import ps2md_pkg::*;

  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;
  logic                   wheel_mode;
  logic                   cfg_write;
  logic                   restart;
  logic                   accept;
  logic                   take;
  logic                   pkt_valid;
  pkt_t                   pkt;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign restart    = cfg_write && (cfg_index == CFG_WHEEL_MODE);
  assign byte_stall = pkt_valid && !take;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
      wheel_mode    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        CFG_WHEEL_MODE:    wheel_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ps2md_assembler u_assembler (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .wheel_mode (wheel_mode),
    .restart    (restart),
    .take       (take),
    .pkt        (pkt),
    .pkt_valid  (pkt_valid)
  );

  ps2md_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .pkt           (pkt),
    .pkt_valid     (pkt_valid),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .take          (take),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .left_button   (left_button),
    .right_button  (right_button),
    .click         (click),
    .wheel_delta   (wheel_delta),
    .redraw        (redraw),
    .result_valid  (result_valid),
    .result_stall  (result_stall)
  );

endmodule

`default_nettype wire
